// ----- hdl/blv_pkg.sv -----
`default_nettype none
package blv_pkg;

  localparam int CoordW   = 16;
  localparam int HeightW  = 8;
  localparam int SpeedW   = 12;
  localparam int GravW    = 8;
  localparam int FramesW  = 17;
  localparam int VelW     = 17;
  localparam int VzW      = 26;

  localparam int DeltaW   = CoordW + 1;
  localparam int DzW      = HeightW + 1;
  localparam int QuarterW = SpeedW - 2;
  localparam int FNumW    = FramesW + 1;
  localparam int GDenW    = GravW + 2;
  localparam int ProdW    = 42;
  localparam int ZQuoW    = VzW - 1;

  typedef struct packed {
    logic                       bad;
    logic [DeltaW-1:0]          dx;
    logic [DeltaW-1:0]          dy;
    logic [DzW-1:0]             dz;
    logic [GravW-1:0]           g;
    logic [SpeedW-1:0]          speed;
    logic [QuarterW-1:0]        quarter;
    logic [FramesW-1:0]         f;
    logic [SpeedW-1:0]          fa;
    logic [HeightW-1:0]         fb;
    logic [FramesW-1:0]         f2;
    logic                       zneg;
    logic                       xneg;
    logic                       yneg;
    logic [ZQuoW-1:0]           vz;
    logic [VelW-1:0]            vx;
    logic [VelW-1:0]            vy;
  } side_t;

  localparam int SideW = $bits(side_t);

endpackage
`default_nettype wire

// ----- hdl/blv_div_cell.sv -----
`default_nettype none
module blv_div_cell #(
  parameter int WN = 18,
  parameter int WD = 12,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire logic [WN-1:0] in_num,
  input  wire logic [WD-1:0] in_rem,
  input  wire logic [WD-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      logic [WN-1:0] out_num,
  output      logic [WD-1:0] out_rem,
  output      logic [WD-1:0] out_den,
  output      logic [SW-1:0] out_side
);

  logic [WD:0]   trial;
  logic [WD:0]   diff;
  logic          fits;
  logic [WD-1:0] rem_next;
  logic [WN-1:0] num_next;

  // one restoring step: bring down the top numerator bit, subtract if it fits
  always_comb begin
    trial    = {in_rem, in_num[WN-1]};
    fits     = trial >= {1'b0, in_den};
    diff     = trial - {1'b0, in_den};
    rem_next = fits ? diff[WD-1:0] : trial[WD-1:0];
    num_next = {in_num[WN-2:0], fits};
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_num  <= num_next;
      out_rem  <= rem_next;
      out_den  <= in_den;
      out_side <= in_side;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/blv_div_chain.sv -----
`default_nettype none
module blv_div_chain #(
  parameter int WN = 18,
  parameter int WD = 12,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire logic [WN-1:0] in_num,
  input  wire logic [WD-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      logic [WN-1:0] quo,
  output      logic [SW-1:0] out_side
);

  logic [WN:0]   v;
  logic [WN:0]   rdy;
  logic [WN-1:0] num  [0:WN];
  logic [WD-1:0] rem  [0:WN];
  logic [WD-1:0] den  [0:WN];
  logic [SW-1:0] side [0:WN];

  assign v[0]      = in_valid;
  assign in_ready  = rdy[0];
  assign num[0]    = in_num;
  assign rem[0]    = '0;
  assign den[0]    = in_den;
  assign side[0]   = in_side;
  assign rdy[WN]   = out_ready;
  assign out_valid = v[WN];
  assign quo       = num[WN];
  assign out_side  = side[WN];

  // one cell per quotient bit, msb first
  for (genvar j = 0; j < WN; j++) begin : g_cell
    blv_div_cell #(.WN(WN), .WD(WD), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v[j]),
      .in_ready (rdy[j]),
      .in_num   (num[j]),
      .in_rem   (rem[j]),
      .in_den   (den[j]),
      .in_side  (side[j]),
      .out_valid(v[j+1]),
      .out_ready(rdy[j+1]),
      .out_num  (num[j+1]),
      .out_rem  (rem[j+1]),
      .out_den  (den[j+1]),
      .out_side (side[j+1])
    );
  end

endmodule
`default_nettype wire

// ----- hdl/ballistic_launch_velocity.sv -----
`default_nettype none
// Launch velocity solver. One request word per cycle is taken while in_ready is high, and
// one result word is given per request, in order.
// The pipeline is made of the rows of one-bit divider cells: 18, 12 and 8 cells for the
// flight time, the gravity cap and the height cap, then 42, 17 and 17 cells for the
// z, x and y speeds, plus eight register stages for input, the four multipliers,
// the flight-length choice, the numerator setup and the output. Every stage stalls
// on its own, so a held output word only stops the pipeline once it is full.
module ballistic_launch_velocity (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [blv_pkg::CoordW-1:0]    start_x,
  input  wire logic [blv_pkg::CoordW-1:0]    start_y,
  input  wire logic [blv_pkg::HeightW-1:0]   start_z,
  input  wire logic [blv_pkg::CoordW-1:0]    target_x,
  input  wire logic [blv_pkg::CoordW-1:0]    target_y,
  input  wire logic [blv_pkg::HeightW-1:0]   target_z,
  input  wire logic [blv_pkg::SpeedW-1:0]    launch_speed,
  input  wire logic [blv_pkg::GravW-1:0]     fall_rate,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [blv_pkg::FramesW-1:0]   flight_frames,
  output      logic signed [blv_pkg::VelW-1:0] velocity_x,
  output      logic signed [blv_pkg::VelW-1:0] velocity_y,
  output      logic signed [blv_pkg::VzW-1:0]  velocity_z,
  output      logic                          bad_speed
);

  localparam int DW  = blv_pkg::DeltaW;
  localparam int FW  = blv_pkg::FramesW;
  localparam int PW  = blv_pkg::ProdW;
  localparam int SW  = blv_pkg::SideW;
  localparam int QFW = blv_pkg::QuarterW + 1 + FW;

  // ---------------- input stage ----------------
  logic                      p_v, p_rdy;
  blv_pkg::side_t            p_side, p_side_next;
  logic [blv_pkg::FNumW-1:0] p_fnum, p_fnum_next;
  logic [DW-1:0]             adx, ady, rng;
  logic                      a_rdy;

  always_comb begin
    p_side_next         = '0;
    p_side_next.bad     = launch_speed == '0;
    p_side_next.dx      = {1'b0, target_x} - {1'b0, start_x};
    p_side_next.dy      = {1'b0, target_y} - {1'b0, start_y};
    p_side_next.dz      = {1'b0, target_z} - {1'b0, start_z};
    p_side_next.g       = fall_rate;
    p_side_next.speed   = launch_speed;
    p_side_next.quarter = launch_speed[blv_pkg::SpeedW-1:2];
    adx = p_side_next.dx[DW-1] ? -p_side_next.dx : p_side_next.dx;
    ady = p_side_next.dy[DW-1] ? -p_side_next.dy : p_side_next.dy;
    rng = adx + ady;
    // rounded division: add half the speed first
    p_fnum_next = {1'b0, rng} + {7'b0, launch_speed[blv_pkg::SpeedW-1:1]};
  end

  assign p_rdy    = ~p_v | a_rdy;
  assign in_ready = p_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (p_rdy) begin
      p_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_rdy && in_valid) begin
      p_side <= p_side_next;
      p_fnum <= p_fnum_next;
    end
  end

  // ---------------- flight time: (range + speed/2) / speed ----------------
  logic                      a_ov, b_rdy;
  logic [blv_pkg::FNumW-1:0] a_quo;
  blv_pkg::side_t            a_side, b_in;

  blv_div_chain #(.WN(blv_pkg::FNumW), .WD(blv_pkg::SpeedW), .SW(SW)) u_div_f (
    .clk(clk), .rst(rst),
    .in_valid(p_v), .in_ready(a_rdy),
    .in_num(p_fnum), .in_den(p_side.speed), .in_side(p_side),
    .out_valid(a_ov), .out_ready(b_rdy),
    .quo(a_quo), .out_side(a_side)
  );

  always_comb begin
    b_in   = a_side;
    b_in.f = a_quo[FW-1:0];
  end

  // ---------------- gravity cap: speed / (4g) ----------------
  logic                       b_ov, c_rdy;
  logic [blv_pkg::SpeedW-1:0] b_quo;
  blv_pkg::side_t             b_side, c_in;
  logic [DW-2:0]              dzabs;

  blv_div_chain #(.WN(blv_pkg::SpeedW), .WD(blv_pkg::GDenW), .SW(SW)) u_div_a (
    .clk(clk), .rst(rst),
    .in_valid(a_ov), .in_ready(b_rdy),
    .in_num(b_in.speed), .in_den({b_in.g, 2'b00}), .in_side(b_in),
    .out_valid(b_ov), .out_ready(c_rdy),
    .quo(b_quo), .out_side(b_side)
  );

  always_comb begin
    c_in    = b_side;
    c_in.fa = b_quo;
  end

  // ---------------- height cap: |dz| / quarter ----------------
  logic                        d_ov, m1_rdy;
  logic [blv_pkg::HeightW-1:0] d_quo;
  logic [blv_pkg::DzW-1:0]     dzneg;
  blv_pkg::side_t              d_side, d_in;

  always_comb begin
    dzneg = -c_in.dz;
    dzabs = '0;
    dzabs[blv_pkg::HeightW-1:0] = c_in.dz[blv_pkg::DzW-1] ? dzneg[blv_pkg::HeightW-1:0]
                                                          : c_in.dz[blv_pkg::HeightW-1:0];
  end

  blv_div_chain #(.WN(blv_pkg::HeightW), .WD(blv_pkg::QuarterW), .SW(SW)) u_div_b (
    .clk(clk), .rst(rst),
    .in_valid(b_ov), .in_ready(c_rdy),
    .in_num(dzabs[blv_pkg::HeightW-1:0]), .in_den(c_in.quarter), .in_side(c_in),
    .out_valid(d_ov), .out_ready(m1_rdy),
    .quo(d_quo), .out_side(d_side)
  );

  always_comb begin
    d_in    = d_side;
    d_in.fb = d_quo;
  end

  // ---------------- f*(f-1) ----------------
  logic              m1_v, m2_rdy;
  blv_pkg::side_t    m1_side;
  logic [2*FW-1:0]   m1_p;

  assign m1_rdy = ~m1_v | m2_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (m1_rdy) begin
      m1_v <= d_ov;
    end
  end

  always_ff @(posedge clk) begin
    if (m1_rdy && d_ov) begin
      m1_side <= d_in;
      m1_p    <= d_in.f * (d_in.f - FW'(1));
    end
  end

  // ---------------- g*f*(f-1) and (quarter+1)*f ----------------
  logic              m2_v, k_rdy;
  blv_pkg::side_t    m2_side;
  logic [PW-1:0]     m2_prod;
  logic [QFW-1:0]    m2_qf;

  assign m2_rdy = ~m2_v | k_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (m2_rdy) begin
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (m2_rdy && m1_v) begin
      m2_side <= m1_side;
      m2_prod <= m1_p * m1_side.g;
      m2_qf   <= ({1'b0, m1_side.quarter} + (blv_pkg::QuarterW + 1)'(1)) * m1_side.f;
    end
  end

  // ---------------- choose the flight length ----------------
  logic              k_v, m3_rdy;
  blv_pkg::side_t    k_side, k_side_next;
  logic [PW:0]       n1;
  logic              over, dz_pos;

  always_comb begin
    n1     = {2'b0, m2_prod[PW-1:1]} + {{(PW + 1 - blv_pkg::DzW){m2_side.dz[blv_pkg::DzW-1]}},
                                         m2_side.dz};
    // first vertical speed above quarter, without dividing
    over   = (m2_side.f != '0) && !n1[PW] && (n1[PW-1:0] >= {{(PW - QFW){1'b0}}, m2_qf});
    dz_pos = !m2_side.dz[blv_pkg::DzW-1] && (m2_side.dz != '0);
    k_side_next    = m2_side;
    k_side_next.f2 = m2_side.f;
    if (over) begin
      if ((m2_side.g == '0) || ({{(FW - blv_pkg::SpeedW){1'b0}}, m2_side.fa} <= m2_side.f)) begin
        if ((m2_side.quarter != '0) && dz_pos &&
            ({{(FW - blv_pkg::HeightW){1'b0}}, m2_side.fb} > m2_side.f)) begin
          k_side_next.f2 = {{(FW - blv_pkg::HeightW){1'b0}}, m2_side.fb};
        end
      end else begin
        k_side_next.f2 = {{(FW - blv_pkg::SpeedW){1'b0}}, m2_side.fa};
      end
    end
  end

  assign k_rdy = ~k_v | m3_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else if (k_rdy) begin
      k_v <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (k_rdy && m2_v) begin
      k_side <= k_side_next;
    end
  end

  // ---------------- f2*(f2-1) ----------------
  logic              m3_v, m4_rdy;
  blv_pkg::side_t    m3_side;
  logic [2*FW-1:0]   m3_p;

  assign m3_rdy = ~m3_v | m4_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_v <= 1'b0;
    end else if (m3_rdy) begin
      m3_v <= k_v;
    end
  end

  always_ff @(posedge clk) begin
    if (m3_rdy && k_v) begin
      m3_side <= k_side;
      m3_p    <= k_side.f2 * (k_side.f2 - FW'(1));
    end
  end

  // ---------------- g*f2*(f2-1) ----------------
  logic              m4_v, n_rdy;
  blv_pkg::side_t    m4_side;
  logic [PW-1:0]     m4_prod;

  assign m4_rdy = ~m4_v | n_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_v <= 1'b0;
    end else if (m4_rdy) begin
      m4_v <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (m4_rdy && m3_v) begin
      m4_side <= m3_side;
      m4_prod <= m3_p * m3_side.g;
    end
  end

  // ---------------- signed numerators to sign and magnitude ----------------
  logic              n_v, z_rdy;
  blv_pkg::side_t    n_side, n_side_next;
  logic [PW-1:0]     n_zmag, n_zmag_next;
  logic [PW:0]       n2, n2neg;
  logic [DW:0]       xnum, ynum, xabs, yabs;

  always_comb begin
    n2    = {2'b0, m4_prod[PW-1:1]} + {{(PW + 1 - blv_pkg::DzW){m4_side.dz[blv_pkg::DzW-1]}},
                                        m4_side.dz};
    n2neg = -n2;
    n_zmag_next = n2[PW] ? n2neg[PW-1:0] : n2[PW-1:0];
    xnum  = {m4_side.dx[DW-1], m4_side.dx} + {2'b0, m4_side.f2[FW-1:1]};
    ynum  = {m4_side.dy[DW-1], m4_side.dy} + {2'b0, m4_side.f2[FW-1:1]};
    xabs  = xnum[DW] ? -xnum : xnum;
    yabs  = ynum[DW] ? -ynum : ynum;
    n_side_next      = m4_side;
    n_side_next.zneg = n2[PW];
    n_side_next.xneg = xnum[DW];
    n_side_next.yneg = ynum[DW];
    // the speed fields carry the magnitudes into their dividers
    n_side_next.vx   = xabs[DW-1:0];
    n_side_next.vy   = yabs[DW-1:0];
  end

  assign n_rdy = ~n_v | z_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v <= 1'b0;
    end else if (n_rdy) begin
      n_v <= m4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (n_rdy && m4_v) begin
      n_side <= n_side_next;
      n_zmag <= n_zmag_next;
    end
  end

  // ---------------- vertical speed ----------------
  logic              z_ov, x_rdy;
  logic [PW-1:0]     z_quo;
  blv_pkg::side_t    z_side, x_in;

  blv_div_chain #(.WN(PW), .WD(FW), .SW(SW)) u_div_z (
    .clk(clk), .rst(rst),
    .in_valid(n_v), .in_ready(z_rdy),
    .in_num(n_zmag), .in_den(n_side.f2), .in_side(n_side),
    .out_valid(z_ov), .out_ready(x_rdy),
    .quo(z_quo), .out_side(z_side)
  );

  always_comb begin
    x_in    = z_side;
    x_in.vz = z_quo[blv_pkg::ZQuoW-1:0];
  end

  // ---------------- x speed ----------------
  logic              x_ov, y_rdy;
  logic [DW-1:0]     x_quo;
  blv_pkg::side_t    x_side, y_in;

  blv_div_chain #(.WN(DW), .WD(FW), .SW(SW)) u_div_x (
    .clk(clk), .rst(rst),
    .in_valid(z_ov), .in_ready(x_rdy),
    .in_num(x_in.vx), .in_den(x_in.f2), .in_side(x_in),
    .out_valid(x_ov), .out_ready(y_rdy),
    .quo(x_quo), .out_side(x_side)
  );

  always_comb begin
    y_in    = x_side;
    y_in.vx = x_quo;
  end

  // ---------------- y speed ----------------
  logic              y_ov, o_rdy;
  logic [DW-1:0]     y_quo;
  blv_pkg::side_t    y_side;

  blv_div_chain #(.WN(DW), .WD(FW), .SW(SW)) u_div_y (
    .clk(clk), .rst(rst),
    .in_valid(x_ov), .in_ready(y_rdy),
    .in_num(y_in.vy), .in_den(y_in.f2), .in_side(y_in),
    .out_valid(y_ov), .out_ready(o_rdy),
    .quo(y_quo), .out_side(y_side)
  );

  // ---------------- output word ----------------
  logic [FW-1:0]           frames_next;
  logic [blv_pkg::VelW-1:0] vx_next, vy_next;
  logic [blv_pkg::VzW-1:0] vz_next, vz_mag, q_ext;

  always_comb begin
    vz_mag = {1'b0, y_side.vz};
    q_ext  = {{(blv_pkg::VzW - blv_pkg::QuarterW){1'b0}}, y_side.quarter};
    frames_next = '0;
    vx_next     = '0;
    vy_next     = '0;
    vz_next     = '0;
    if (!y_side.bad) begin
      if (y_side.f == '0) begin
        // no frames: only a capped vertical speed
        vz_next = (!y_side.dz[blv_pkg::DzW-1] && (y_side.dz != '0)) ? q_ext : -q_ext;
      end else begin
        frames_next = y_side.f2;
        vx_next     = y_side.xneg ? -y_side.vx : y_side.vx;
        vy_next     = y_side.yneg ? -y_quo : y_quo;
        vz_next     = y_side.zneg ? -vz_mag : vz_mag;
      end
    end
  end

  assign o_rdy = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_rdy) begin
      out_valid <= y_ov;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && y_ov) begin
      flight_frames <= frames_next;
      velocity_x    <= vx_next;
      velocity_y    <= vy_next;
      velocity_z    <= vz_next;
      bad_speed     <= y_side.bad;
    end
  end

  // the input only stalls behind a full pipeline and a held output word
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled with room in the pipeline");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_speed) |->
      (flight_frames == '0 && velocity_x == '0 && velocity_y == '0 && velocity_z == '0))
    else $error("zero speed word carries nonzero fields");

  a_no_frames: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !bad_speed && flight_frames == '0) |->
      (velocity_x == '0 && velocity_y == '0))
    else $error("zero frame word carries horizontal speed");

endmodule
`default_nettype wire
